// ===== rtl/spmv_pkg.sv =====
// shared types and constants of the sparse matrix-vector multiply core
package spmv_pkg;

  localparam int unsigned X_DEPTH_DEF     = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned INDEX_WIDTH     = 10;
  localparam int unsigned REQ_WIDTH       = 2;
  localparam int unsigned ROW_WIDTH       = 16;
  localparam int unsigned FIELD_WIDTH     = 32;
  localparam int unsigned ACC_WIDTH       = 64;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_X_WRITE = 2'd0,
    REQ_TERM    = 2'd1,
    REQ_EMPTY   = 2'd2
  } spmv_req_e;

  // one queued operation for the accumulate side
  typedef struct packed {
    logic                        last;
    logic                        is_term;
    logic signed [ACC_WIDTH-1:0] prod;
  } spmv_op_t;

endpackage

// ===== rtl/spmv_in_if.sv =====
// request channel: x entry writes, nonzero terms and empty rows
interface spmv_in_if;
  import spmv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [REQ_WIDTH-1:0]          req_type;
  logic [INDEX_WIDTH-1:0]        index;
  logic signed [FIELD_WIDTH-1:0] value;
  logic                          row_last;

  modport source (output valid, output req_type, output index, output value,
                  output row_last, input ready);
  modport sink (input valid, input req_type, input index, input value,
                input row_last, output ready);
endinterface

// ===== rtl/spmv_out_if.sv =====
// result channel: row number, saturated row sum and saturation flag
interface spmv_out_if;
  import spmv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [ROW_WIDTH-1:0]          row;
  logic signed [FIELD_WIDTH-1:0] sum;
  logic                          saturated;

  modport source (output valid, output row, output sum, output saturated,
                  input ready);
  modport sink (input valid, input row, input sum, input saturated,
                output ready);
endinterface

// ===== rtl/spmv_front.sv =====
// front end: request decode, x store, x lookup and term multiply
module spmv_front #(
  parameter int unsigned X_DEPTH     = spmv_pkg::X_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = spmv_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  spmv_in_if.sink            in_i,
  output spmv_pkg::spmv_op_t op_o,
  output logic               op_valid_o,
  input  logic               op_ready_i
);
  import spmv_pkg::*;

  localparam int unsigned AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
  localparam int unsigned CW = ((AW > INDEX_WIDTH) ? AW : INDEX_WIDTH) + 1;
  localparam int unsigned PW = 2 * VALUE_WIDTH;

  logic                          adv;
  logic                          accept;
  spmv_req_e                     req;
  logic [CW-1:0]                 idx_ext;
  logic                          in_range;
  logic [AW-1:0]                 addr;
  logic signed [VALUE_WIDTH-1:0] val;

  logic [VALUE_WIDTH-1:0]        x_store_q [X_DEPTH];
  logic [VALUE_WIDTH-1:0]        x_rd_q;

  // lookup stage
  logic                          s1_valid_q;
  logic                          s1_term_q;
  logic                          s1_last_q;
  logic                          s1_inr_q;
  logic signed [VALUE_WIDTH-1:0] s1_val_q;

  // product stage
  logic                          p_valid_q;
  logic                          p_term_q;
  logic                          p_last_q;
  logic signed [ACC_WIDTH-1:0]   prod_q;

  logic signed [VALUE_WIDTH-1:0] x_sel;
  logic signed [PW-1:0]          mul;

  assign adv      = !p_valid_q || op_ready_i;
  assign in_i.ready = adv;
  assign accept   = in_i.valid && adv;
  assign req      = spmv_req_e'(in_i.req_type);
  assign idx_ext  = CW'(in_i.index);
  assign in_range = idx_ext < CW'(X_DEPTH);
  assign addr     = idx_ext[AW-1:0];
  assign val      = in_i.value[VALUE_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (accept && (req == REQ_X_WRITE) && in_range) begin
      x_store_q[addr] <= val;
    end
    if (adv) begin
      x_rd_q <= x_store_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && ((req == REQ_TERM) || (req == REQ_EMPTY));
      p_valid_q  <= s1_valid_q;
    end
  end

  // out-of-range columns read as zero
  assign x_sel = s1_inr_q ? signed'(x_rd_q) : '0;
  assign mul   = s1_val_q * x_sel;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_term_q <= (req == REQ_TERM);
      s1_last_q <= in_i.row_last;
      s1_inr_q  <= in_range;
      s1_val_q  <= val;
      p_term_q  <= s1_term_q;
      p_last_q  <= s1_last_q;
      prod_q    <= s1_term_q ? ACC_WIDTH'(mul) : '0;
    end
  end

  assign op_o.last    = p_last_q;
  assign op_o.is_term = p_term_q;
  assign op_o.prod    = prod_q;
  assign op_valid_o   = p_valid_q;

endmodule

// ===== rtl/spmv_queue.sv =====
// short operation queue between front end and accumulator
module spmv_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spmv_pkg::spmv_op_t push_data_i,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  output spmv_pkg::spmv_op_t pop_data_o,
  output logic               pop_valid_o,
  input  logic               pop_ready_i
);
  import spmv_pkg::*;

  spmv_op_t            entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_CW-1:0] count_q;
  logic                push, pop;

  assign push_ready_o = count_q != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spmv_back.sv =====
// back end: saturating accumulate, rounding narrow, row numbering, result register
module spmv_back #(
  parameter int unsigned VALUE_WIDTH = spmv_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spmv_pkg::spmv_op_t             op_i,
  input  logic                           op_valid_i,
  output logic                           op_ready_o,
  input  logic                           cfg_we_i,
  input  logic [spmv_pkg::ROW_WIDTH-1:0] cfg_wdata_i,
  spmv_out_if.source                     out_o
);
  import spmv_pkg::*;

  localparam int unsigned FRAC = VALUE_WIDTH / 2;
  localparam int unsigned TW   = ACC_WIDTH - FRAC + 1;
  localparam logic signed [TW-1:0] HI = TW'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
  localparam logic signed [TW-1:0] LO = -HI - TW'(1);

  logic                        adv;
  logic                        pop;

  logic signed [ACC_WIDTH-1:0] acc_q;
  logic                        ovf_q;
  logic signed [ACC_WIDTH-1:0] add_raw;
  logic                        add_ovf;
  logic signed [ACC_WIDTH-1:0] add_sat;

  logic                        f_valid_q;
  logic signed [ACC_WIDTH-1:0] f_acc_q;
  logic                        f_ovf_q;

  logic signed [TW-1:0]          shr, rnd, t;
  logic signed [VALUE_WIDTH-1:0] narrow;
  logic                          nsat;

  logic                          out_valid_q;
  logic [ROW_WIDTH-1:0]          row_cnt_q;
  logic [ROW_WIDTH-1:0]          row_q;
  logic signed [FIELD_WIDTH-1:0] sum_q;
  logic                          sat_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign op_ready_o = adv;
  assign pop        = op_valid_i && adv;

  // saturating 64-bit add
  assign add_raw = acc_q + op_i.prod;
  assign add_ovf = (acc_q[ACC_WIDTH-1] == op_i.prod[ACC_WIDTH-1])
                && (add_raw[ACC_WIDTH-1] != acc_q[ACC_WIDTH-1]);
  always_comb begin
    add_sat = add_raw;
    if (add_ovf) begin
      add_sat = acc_q[ACC_WIDTH-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      f_valid_q <= 1'b0;
    end else if (adv) begin
      f_valid_q <= pop && (!op_i.is_term || op_i.last);
      if (pop && op_i.is_term) begin
        if (op_i.last) begin
          acc_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          acc_q <= add_sat;
          ovf_q <= ovf_q || add_ovf;
        end
      end
    end
  end

  // empty rows carry a zero sum and a clear flag
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_acc_q <= op_i.is_term ? add_sat : '0;
      f_ovf_q <= op_i.is_term && (ovf_q || add_ovf);
    end
  end

  // round half up, then clamp to the value range
  assign shr = TW'(f_acc_q >>> FRAC);
  assign rnd = TW'({1'b0, f_acc_q[FRAC-1]});
  assign t   = shr + rnd;

  always_comb begin
    narrow = t[VALUE_WIDTH-1:0];
    nsat   = 1'b0;
    if (t > HI) begin
      narrow = HI[VALUE_WIDTH-1:0];
      nsat   = 1'b1;
    end else if (t < LO) begin
      narrow = LO[VALUE_WIDTH-1:0];
      nsat   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      row_cnt_q   <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= f_valid_q;
      end
      // a register write takes priority over the row step
      priority if (cfg_we_i) begin
        row_cnt_q <= cfg_wdata_i;
      end else if (adv && f_valid_q) begin
        row_cnt_q <= row_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && f_valid_q) begin
      row_q <= row_cnt_q;
      sum_q <= FIELD_WIDTH'(narrow);
      sat_q <= f_ovf_q || nsat;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row       = row_q;
  assign out_o.sum       = sum_q;
  assign out_o.saturated = sat_q;

endmodule

// ===== rtl/csr_sparse_matrix_vector_multiply_core.sv =====
// top level of the streaming compressed-row sparse matrix-vector multiply core
//
// computes b = A*x over a stream: x entries are first written into a local
// store by index, then each nonzero term brings a column index and a Q16.16
// value, is multiplied by the stored x entry and summed into a saturating
// 64-bit accumulator; the term marked last of its row emits one result
// (row number, rounded and clamped sum, saturation flag) and clears the
// sum, and an empty-row request emits a zero sum without touching a sum in
// progress. x writes and unknown request codes emit nothing. the core takes
// one request per clock cycle while the queue has room; the rate is set by
// the single saturating add loop on the 64-bit accumulator, the multiply
// sitting in its own stage ahead of it. a result passes from the lookup
// stage through the product stage, the operation queue and the final
// accumulate register into the output register. the x store is one
// single-port-write, single-read memory with no clearing pass: reading an
// entry that was never written gives an undefined sum. columns beyond the
// store depth read as zero. the row counter is reloaded from cfg_wdata_i when
// cfg_we_i is set; write it only while the core is idle
module csr_sparse_matrix_vector_multiply_core #(
  parameter int unsigned X_DEPTH     = spmv_pkg::X_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = spmv_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spmv_in_if.sink                        in_i,
  spmv_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [spmv_pkg::ROW_WIDTH-1:0] cfg_wdata_i
);
  import spmv_pkg::*;

  // front end to queue
  spmv_op_t front_op;
  logic     front_valid;
  logic     q_ready;

  // queue to back end
  spmv_op_t back_op;
  logic     back_valid;
  logic     back_ready;

  // decode, x lookup and multiply; stalls only when the queue is full
  spmv_front #(
    .X_DEPTH     (X_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .op_ready_i (q_ready)
  );

  // decouples the multiply side from a stalled result consumer
  spmv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_op),
    .push_valid_i (front_valid),
    .push_ready_o (q_ready),
    .pop_data_o   (back_op),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // accumulate, narrow, number rows, hold the result for the consumer
  spmv_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (back_op),
    .op_valid_i  (back_valid),
    .op_ready_o  (back_ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  // room in the queue must never block new requests
  a_front_not_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    q_ready |-> in_i.ready
  ) else $error("front end stalled while the queue had room");

  // a held result must stop the accumulator side
  a_back_stalls: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !back_ready
  ) else $error("accumulator advanced while a result was held");

  // a pending result that is not taken is still there next cycle
  a_result_kept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid
  ) else $error("pending result lost");
`endif

endmodule
